// File: rtl/gcl_pkg.sv
// Package for the grid cell locate block: constants, register indexes and config types.
package gcl_pkg;

    localparam int AXIS_CELLS_MAX = 1024;
    localparam int CFG_WIDTH      = 33;
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int COUNT_WIDTH    = 11;
    localparam int IDX_WIDTH      = 10;
    localparam int WEIGHT_WIDTH   = 16;
    localparam int Q_WIDTH        = 32;
    localparam int PROD_WIDTH     = 2 * Q_WIDTH;

    localparam logic [Q_WIDTH-1:0]     INV_RESET = 32'h0001_0000;
    localparam logic [PROD_WIDTH-1:0]  HALF_Q32  = 64'h0000_0000_8000_0000;
    localparam logic [COUNT_WIDTH-1:0] COUNT_SAT = COUNT_WIDTH'(AXIS_CELLS_MAX);

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_ORIGIN_X   = 3'd0,
        REG_ORIGIN_Y   = 3'd1,
        REG_ORIGIN_Z   = 3'd2,
        REG_INV_CELL_X = 3'd3,
        REG_INV_CELL_Y = 3'd4,
        REG_INV_CELL_Z = 3'd5,
        REG_GRID_DIMS  = 3'd6
    } gcl_reg_t;

    // Settings of one axis as seen by the locate pipeline.
    typedef struct packed {
        logic [Q_WIDTH-1:0]   origin;
        logic [Q_WIDTH-1:0]   inv_cell;
        logic [IDX_WIDTH-1:0] last;
        logic                 multi;
    } gcl_axis_cfg_t;

    typedef struct packed {
        gcl_axis_cfg_t x;
        gcl_axis_cfg_t y;
        gcl_axis_cfg_t z;
        logic          grid_ok;
    } gcl_grid_cfg_t;

endpackage

// File: rtl/gcl_cfg.sv
// Configuration register file and per-axis settings decode.
module gcl_cfg
    import gcl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]     cfg_data,
    output gcl_grid_cfg_t            grid
);

    logic [Q_WIDTH-1:0]   origin_x_reg, origin_y_reg, origin_z_reg;
    logic [Q_WIDTH-1:0]   inv_x_reg, inv_y_reg, inv_z_reg;
    logic [CFG_WIDTH-1:0] dims_reg;

    logic [COUNT_WIDTH-1:0] cnt_x, cnt_y, cnt_z;
    logic [COUNT_WIDTH-1:0] n_x, n_y, n_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            inv_x_reg    <= INV_RESET;
            inv_y_reg    <= INV_RESET;
            inv_z_reg    <= INV_RESET;
            dims_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (gcl_reg_t'(cfg_index))
                REG_ORIGIN_X:   origin_x_reg <= cfg_data[Q_WIDTH-1:0];
                REG_ORIGIN_Y:   origin_y_reg <= cfg_data[Q_WIDTH-1:0];
                REG_ORIGIN_Z:   origin_z_reg <= cfg_data[Q_WIDTH-1:0];
                REG_INV_CELL_X: inv_x_reg    <= cfg_data[Q_WIDTH-1:0];
                REG_INV_CELL_Y: inv_y_reg    <= cfg_data[Q_WIDTH-1:0];
                REG_INV_CELL_Z: inv_z_reg    <= cfg_data[Q_WIDTH-1:0];
                REG_GRID_DIMS:  dims_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign cnt_x = dims_reg[COUNT_WIDTH-1:0];
    assign cnt_y = dims_reg[2*COUNT_WIDTH-1:COUNT_WIDTH];
    assign cnt_z = dims_reg[3*COUNT_WIDTH-1:2*COUNT_WIDTH];

    // Counts above the grid limit saturate to it.
    assign n_x = (cnt_x > COUNT_SAT) ? COUNT_SAT : cnt_x;
    assign n_y = (cnt_y > COUNT_SAT) ? COUNT_SAT : cnt_y;
    assign n_z = (cnt_z > COUNT_SAT) ? COUNT_SAT : cnt_z;

    always_comb
    begin
        grid.x.origin   = origin_x_reg;
        grid.x.inv_cell = inv_x_reg;
        grid.x.last     = IDX_WIDTH'(n_x - COUNT_WIDTH'(1));
        grid.x.multi    = (n_x > COUNT_WIDTH'(1));
        grid.y.origin   = origin_y_reg;
        grid.y.inv_cell = inv_y_reg;
        grid.y.last     = IDX_WIDTH'(n_y - COUNT_WIDTH'(1));
        grid.y.multi    = (n_y > COUNT_WIDTH'(1));
        grid.z.origin   = origin_z_reg;
        grid.z.inv_cell = inv_z_reg;
        grid.z.last     = IDX_WIDTH'(n_z - COUNT_WIDTH'(1));
        grid.z.multi    = (n_z > COUNT_WIDTH'(1));
        grid.grid_ok    = (n_x != '0) && (n_y != '0) && (n_z != '0) &&
                          (inv_x_reg != '0) && (inv_y_reg != '0) && (inv_z_reg != '0);
    end

endmodule

// File: rtl/gcl_axis.sv
// Three-stage locate pipeline for one axis: offset, scale, then split and saturate.
module gcl_axis
    import gcl_pkg::*;
(
    input  logic                      clk,
    input  logic [Q_WIDTH-1:0]        pos,
    input  gcl_axis_cfg_t             acfg,
    output logic [IDX_WIDTH-1:0]      lower,
    output logic [IDX_WIDTH-1:0]      upper,
    output logic [WEIGHT_WIDTH-1:0]   weight
);

    logic [Q_WIDTH:0]            diff;
    logic                        d_pos_next;
    logic [Q_WIDTH-1:0]          d_reg;
    logic                        d_pos_reg;
    logic [PROD_WIDTH-1:0]       prod_reg;
    logic                        p_pos_reg;
    logic [PROD_WIDTH-1:0]       coord;
    logic                        above_half;
    logic                        at_last;
    logic [IDX_WIDTH-1:0]        lower_next, upper_next;
    logic [WEIGHT_WIDTH-1:0]     weight_next;
    logic [IDX_WIDTH-1:0]        lower_reg, upper_reg;
    logic [WEIGHT_WIDTH-1:0]     weight_reg;

    // Stage 1: exact 33-bit signed offset from the grid minimum.
    assign diff       = {pos[Q_WIDTH-1], pos} - {acfg.origin[Q_WIDTH-1], acfg.origin};
    assign d_pos_next = !diff[Q_WIDTH] && (diff != '0);

    always_ff @(posedge clk)
    begin
        d_reg     <= diff[Q_WIDTH-1:0];
        d_pos_reg <= d_pos_next;
    end

    // Stage 2: scale to a Q32.32 cell coordinate; a positive offset fits in 32 bits.
    always_ff @(posedge clk)
    begin
        prod_reg  <= d_reg * acfg.inv_cell;
        p_pos_reg <= d_pos_reg;
    end

    // Stage 3: shift to cell centers, then clamp at either end of the axis.
    assign above_half = (prod_reg > HALF_Q32);
    assign coord      = prod_reg - HALF_Q32;
    assign at_last    = (coord[PROD_WIDTH-1:Q_WIDTH] >= {{(Q_WIDTH-IDX_WIDTH){1'b0}}, acfg.last});

    always_comb
    begin
        lower_next  = '0;
        upper_next  = '0;
        weight_next = '0;
        if (acfg.multi && p_pos_reg && above_half)
        begin
            if (at_last)
            begin
                lower_next = acfg.last;
                upper_next = acfg.last;
            end
            else
            begin
                lower_next  = coord[Q_WIDTH+IDX_WIDTH-1:Q_WIDTH];
                upper_next  = coord[Q_WIDTH+IDX_WIDTH-1:Q_WIDTH] + IDX_WIDTH'(1);
                weight_next = coord[Q_WIDTH-1:Q_WIDTH-WEIGHT_WIDTH];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lower_reg  <= lower_next;
        upper_reg  <= upper_next;
        weight_reg <= weight_next;
    end

    assign lower  = lower_reg;
    assign upper  = upper_reg;
    assign weight = weight_reg;

endmodule

// File: rtl/grid_cell_locate_trilinear.sv
// Top level of the trilinear grid cell locate block.
//
//  channel   | signals                                  | handshake
//  ----------+------------------------------------------+------------------------------
//  input     | pos_x, pos_y, pos_z                      | beat taken when start && !busy
//  result    | valid_res, lower_*, upper_*, weight_*    | beat shown while done is high
//  config    | cfg_index, cfg_data                      | written when cfg_we is high
//
// Every beat passes an offset stage, a 32 x 32 multiply stage, and a split and saturate
// stage per axis. Done rises together with the registered result of the last stage, and
// the receiver takes the result while done is high.
// A new beat may enter in every cycle, so busy is never raised.
// Reset (rst_n, asynchronous, active low) clears the pipeline strobes and returns the
// configuration registers to their reset values; any beat in flight is lost.
// The receiver cannot stall, so each result is presented for exactly one cycle.
module grid_cell_locate_trilinear
    import gcl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [Q_WIDTH-1:0] pos_x,
    input  logic signed [Q_WIDTH-1:0] pos_y,
    input  logic signed [Q_WIDTH-1:0] pos_z,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]     cfg_data,
    output logic                     done,
    output logic                     valid_res,
    output logic [IDX_WIDTH-1:0]     lower_x,
    output logic [IDX_WIDTH-1:0]     upper_x,
    output logic [WEIGHT_WIDTH-1:0]  weight_x,
    output logic [IDX_WIDTH-1:0]     lower_y,
    output logic [IDX_WIDTH-1:0]     upper_y,
    output logic [WEIGHT_WIDTH-1:0]  weight_y,
    output logic [IDX_WIDTH-1:0]     lower_z,
    output logic [IDX_WIDTH-1:0]     upper_z,
    output logic [WEIGHT_WIDTH-1:0]  weight_z
);

    localparam int DEPTH = 3;

    gcl_grid_cfg_t           grid;
    logic [DEPTH-1:0]        strobe_reg;
    logic [DEPTH-1:0]        strobe_next;
    logic [IDX_WIDTH-1:0]    lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
    logic [WEIGHT_WIDTH-1:0] w_x, w_y, w_z;
    logic                    accept;

    // The user must change the configuration only while the pipeline is empty; the
    // block does not enforce this, and every stage reads the live register values.
    gcl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .grid      (grid)
    );

    gcl_axis u_axis_x (
        .clk    (clk),
        .pos    (pos_x),
        .acfg   (grid.x),
        .lower  (lo_x),
        .upper  (hi_x),
        .weight (w_x)
    );

    gcl_axis u_axis_y (
        .clk    (clk),
        .pos    (pos_y),
        .acfg   (grid.y),
        .lower  (lo_y),
        .upper  (hi_y),
        .weight (w_y)
    );

    gcl_axis u_axis_z (
        .clk    (clk),
        .pos    (pos_z),
        .acfg   (grid.z),
        .lower  (lo_z),
        .upper  (hi_z),
        .weight (w_z)
    );

    // The pipeline never holds, so busy stays low and a beat enters on every start.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // The strobe travels alongside the payload through the three stages.
    assign strobe_next = {strobe_reg[DEPTH-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= '0;
        end
        else
        begin
            strobe_reg <= strobe_next;
        end
    end

    assign done = strobe_reg[DEPTH-1];

    // An unusable grid reports zero in every field.
    assign valid_res = grid.grid_ok;
    assign lower_x   = grid.grid_ok ? lo_x : '0;
    assign upper_x   = grid.grid_ok ? hi_x : '0;
    assign weight_x  = grid.grid_ok ? w_x  : '0;
    assign lower_y   = grid.grid_ok ? lo_y : '0;
    assign upper_y   = grid.grid_ok ? hi_y : '0;
    assign weight_y  = grid.grid_ok ? w_y  : '0;
    assign lower_z   = grid.grid_ok ? lo_z : '0;
    assign upper_z   = grid.grid_ok ? hi_z : '0;
    assign weight_z  = grid.grid_ok ? w_z  : '0;

endmodule

// File: tb/grid_cell_locate_trilinear_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the trilinear grid cell locate block.
module grid_cell_locate_trilinear_tb;
    import gcl_pkg::*;

    // A position is three Q16.16 coordinates; index 0 is x, 1 is y, 2 is z.
    typedef logic [Q_WIDTH-1:0] coord_t;
    typedef coord_t [2:0] position_t;

    // Located neighbours on one axis, and the full result of one beat.
    typedef struct packed {
        logic [IDX_WIDTH-1:0]    lower;
        logic [IDX_WIDTH-1:0]    upper;
        logic [WEIGHT_WIDTH-1:0] weight;
    } axis_loc_t;

    typedef struct packed {
        logic                valid;
        axis_loc_t [2:0]     ax;
    } cell_loc_t;

    // The half-cell offset of a cell-centred grid, as Q32.32.
    localparam logic [63:0] HALF_CELL_Q32 = 64'h0000_0000_8000_0000;
    // Cycles with no beat in either direction before the run is declared hung.
    localparam int STALL_LIMIT = 2000;
    // Pipeline depth from acceptance to done, plus a margin, for the final wait.
    localparam int DRAIN_CYCLES = 8;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic signed [Q_WIDTH-1:0] pos_x = '0;
    logic signed [Q_WIDTH-1:0] pos_y = '0;
    logic signed [Q_WIDTH-1:0] pos_z = '0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_WIDTH-1:0]     cfg_data = '0;
    logic                     done;
    logic                     valid_res;
    logic [IDX_WIDTH-1:0]     lower_x, upper_x, lower_y, upper_y, lower_z, upper_z;
    logic [WEIGHT_WIDTH-1:0]  weight_x, weight_y, weight_z;

    grid_cell_locate_trilinear u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .valid_res (valid_res),
        .lower_x   (lower_x),
        .upper_x   (upper_x),
        .weight_x  (weight_x),
        .lower_y   (lower_y),
        .upper_y   (upper_y),
        .weight_y  (weight_y),
        .lower_z   (lower_z),
        .upper_z   (upper_z),
        .weight_z  (weight_z)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Shadow copy of the grid registers, updated whenever the testbench writes one.
    // Writes only happen while the block is empty, so a beat is always predicted
    // with the settings the block itself uses.
    coord_t             grid_origin [3] = '{'0, '0, '0};
    logic [Q_WIDTH-1:0] grid_inv_cell [3] = '{INV_RESET, INV_RESET, INV_RESET};
    logic [CFG_WIDTH-1:0] grid_dims_reg = '0;

    position_t positions_to_send [$];   // filled by the stimulus, drained by the driver
    cell_loc_t expected_cells [$];      // one entry per accepted beat, oldest first
    int        idle_pct = 0;            // chance in percent that the driver sits out a cycle
    bit        beat_taken = 1'b0;       // set at the rising edge that accepts a beat
    int        stall_cycles = 0;
    int unsigned mismatches = 0;
    string     axis_tag [3] = '{"x", "y", "z"};

    // Cell count of one axis, saturated the same way the block saturates it.
    function automatic logic [COUNT_WIDTH-1:0] axis_cells(int a);
        logic [COUNT_WIDTH-1:0] n;
        n = grid_dims_reg[COUNT_WIDTH*a +: COUNT_WIDTH];
        if (n > AXIS_CELLS_MAX)
            n = COUNT_WIDTH'(AXIS_CELLS_MAX);
        return n;
    endfunction

    // Neighbours and weight along one axis. The offset from the origin is exact in
    // 33 signed bits; for a positive offset the product with the inverse cell size is
    // an exact Q32.32 and the half-cell shift moves it onto cell centres.
    function automatic axis_loc_t locate_axis(coord_t pos, coord_t org,
                                              logic [Q_WIDTH-1:0] inv,
                                              logic [COUNT_WIDTH-1:0] count);
        axis_loc_t          r;
        logic signed [32:0] offset;
        logic [63:0]        prod;
        logic [63:0]        coord;
        logic [63:0]        last_q;
        r = '0;
        if (count <= 1)
            return r;
        offset = {pos[31], pos} - {org[31], org};
        if (offset[32] || offset == 0)
            return r;
        prod = 64'(offset[31:0]) * 64'(inv);
        if (prod <= HALF_CELL_Q32)
            return r;
        coord  = prod - HALF_CELL_Q32;
        last_q = {21'd0, count - 11'd1, 32'd0};
        if (coord >= last_q)
        begin
            // At or past the centre of the last cell: both neighbours are the last cell.
            r.lower = IDX_WIDTH'(count - 11'd1);
            r.upper = IDX_WIDTH'(count - 11'd1);
            return r;
        end
        r.lower  = coord[41:32];
        r.upper  = coord[41:32] + 10'd1;
        r.weight = coord[31:16];
        return r;
    endfunction

    // Expected result of one beat under the current shadow settings.
    function automatic cell_loc_t locate_cells(position_t p);
        cell_loc_t r;
        bit        grid_ok;
        r = '0;
        grid_ok = 1'b1;
        for (int a = 0; a < 3; a++)
            if (axis_cells(a) == 0 || grid_inv_cell[a] == 0)
                grid_ok = 1'b0;
        if (!grid_ok)
            return r;
        r.valid = 1'b1;
        for (int a = 0; a < 3; a++)
            r.ax[a] = locate_axis(p[a], grid_origin[a], grid_inv_cell[a], axis_cells(a));
        return r;
    endfunction

    function automatic position_t make_pos(coord_t x, coord_t y, coord_t z);
        position_t p;
        p[0] = x;
        p[1] = y;
        p[2] = z;
        return p;
    endfunction

    // One coordinate for the random part. Most land in or just around the grid,
    // placed by cell index and fraction; a few sit at or below the origin, and a
    // few are plain noise over the whole range.
    function automatic coord_t pick_coord(int a);
        int unsigned mode;
        int unsigned cell_idx;
        logic [31:0] frac;
        logic [63:0] target;
        mode = $urandom_range(9);
        if (mode == 0 || grid_inv_cell[a] == 0)
            return $urandom;
        if (mode == 1)
            return grid_origin[a] - $urandom_range(0, 1 << 20);
        cell_idx = $urandom_range(axis_cells(a));
        frac = (mode == 2) ? 32'd0 : $urandom;
        target = {cell_idx, 32'd0} + HALF_CELL_Q32 + 64'(frac);
        if (mode == 3)
            // Rounded up so that cell boundaries are hit exactly where the size allows.
            return grid_origin[a] + 32'((target + grid_inv_cell[a] - 1) / grid_inv_cell[a]);
        return grid_origin[a] + 32'(target / grid_inv_cell[a]);
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic check_result(cell_loc_t got, cell_loc_t want);
        if (got.valid !== want.valid)
            report_mismatch("valid_res", 64'(got.valid), 64'(want.valid));
        for (int a = 0; a < 3; a++)
        begin
            if (got.ax[a].lower !== want.ax[a].lower)
                report_mismatch({"lower_", axis_tag[a]}, 64'(got.ax[a].lower),
                                64'(want.ax[a].lower));
            if (got.ax[a].upper !== want.ax[a].upper)
                report_mismatch({"upper_", axis_tag[a]}, 64'(got.ax[a].upper),
                                64'(want.ax[a].upper));
            if (got.ax[a].weight !== want.ax[a].weight)
                report_mismatch({"weight_", axis_tag[a]}, 64'(got.ax[a].weight),
                                64'(want.ax[a].weight));
        end
    endtask

    // Register write on the falling edge; the block takes it at the next rising edge.
    task automatic write_reg(gcl_reg_t idx, logic [CFG_WIDTH-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_ORIGIN_X:   grid_origin[0]   = value[31:0];
            REG_ORIGIN_Y:   grid_origin[1]   = value[31:0];
            REG_ORIGIN_Z:   grid_origin[2]   = value[31:0];
            REG_INV_CELL_X: grid_inv_cell[0] = value[31:0];
            REG_INV_CELL_Y: grid_inv_cell[1] = value[31:0];
            REG_INV_CELL_Z: grid_inv_cell[2] = value[31:0];
            REG_GRID_DIMS:  grid_dims_reg    = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Loads the whole grid. The unused top bit of the 32-bit registers gets a random
    // value, since the block must ignore it.
    task automatic load_grid(coord_t ox, coord_t oy, coord_t oz,
                             logic [31:0] ix, logic [31:0] iy, logic [31:0] iz,
                             logic [CFG_WIDTH-1:0] dims);
        write_reg(REG_ORIGIN_X, {1'($urandom), ox});
        write_reg(REG_ORIGIN_Y, {1'($urandom), oy});
        write_reg(REG_ORIGIN_Z, {1'($urandom), oz});
        write_reg(REG_INV_CELL_X, {1'($urandom), ix});
        write_reg(REG_INV_CELL_Y, {1'($urandom), iy});
        write_reg(REG_INV_CELL_Z, {1'($urandom), iz});
        write_reg(REG_GRID_DIMS, dims);
    endtask

    // Holds the sender back until every beat sent so far has come back.
    task automatic wait_drained();
        while (positions_to_send.size() != 0 || start || expected_cells.size() != 0)
            @(posedge clk);
    endtask

    // A random grid: mostly small axes with moderate cell sizes, now and then a
    // single-cell axis, a large or saturating count, or an arbitrary inverse size.
    task automatic randomize_grid();
        coord_t      org [3];
        logic [31:0] inv [3];
        logic [10:0] cnt [3];
        int unsigned kind;
        for (int a = 0; a < 3; a++)
        begin
            org[a] = $urandom;
            org[a] = $signed(org[a]) >>> $urandom_range(2, 20);
            inv[a] = ($urandom_range(7) == 0) ? 32'($urandom_range(1, 32'hFFFF_FFFF))
                                              : 32'($urandom_range(1 << 12, 1 << 22));
            kind = $urandom_range(9);
            if (kind == 0)
                cnt[a] = 11'd1;
            else if (kind == 1)
                cnt[a] = 11'($urandom_range(1000, 2047));
            else
                cnt[a] = 11'($urandom_range(2, 40));
        end
        load_grid(org[0], org[1], org[2], inv[0], inv[1], inv[2],
                  {cnt[2], cnt[1], cnt[0]});
    endtask

    // Driver: a beat offered on start stays put until it is taken, then the next
    // pending position follows, or the line goes idle at the chosen rate.
    always @(negedge clk)
    begin
        position_t next_pos;
        if (!rst_n)
            start <= 1'b0;
        else if (start && !beat_taken)
            ;
        else if (positions_to_send.size() != 0 && $urandom_range(99) >= idle_pct)
        begin
            next_pos = positions_to_send.pop_front();
            start <= 1'b1;
            pos_x <= next_pos[0];
            pos_y <= next_pos[1];
            pos_z <= next_pos[2];
        end
        else
            start <= 1'b0;
    end

    // Monitor: on each rising edge, an accepted input beat is predicted and queued,
    // and a result beat is checked against the oldest prediction. A watchdog counts
    // edges at which neither kind of beat moves.
    always @(posedge clk)
    begin
        cell_loc_t got;
        if (!rst_n)
            beat_taken = 1'b0;
        else
        begin
            beat_taken = start && !busy;
            if (beat_taken)
                expected_cells.push_back(locate_cells(make_pos(pos_x, pos_y, pos_z)));
            if (done)
            begin
                got.valid = valid_res;
                got.ax[0] = {lower_x, upper_x, weight_x};
                got.ax[1] = {lower_y, upper_y, weight_y};
                got.ax[2] = {lower_z, upper_z, weight_z};
                if (expected_cells.size() == 0)
                    report_mismatch("unexpected result", 64'(got.valid), 64'd0);
                else
                    check_result(got, expected_cells.pop_front());
            end
            if (beat_taken || done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles == STALL_LIMIT)
            begin
                $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
                $display("grid_cell_locate_trilinear_tb failed");
                $finish;
            end
        end
    end

    initial
    begin
        int idle_plan [6];
        idle_plan = '{0, 51, 6, 51, 0, 6};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Registers still at reset: no cells on any axis, so results are invalid.
        positions_to_send.push_back(make_pos(32'h0, 32'h0, 32'h0));
        positions_to_send.push_back(make_pos(32'h7FFF_FFFF, 32'h8000_0000, $urandom));
        wait_drained();

        // x: four unit cells from zero, walked across the half-cell point, the interior,
        // the last centre and both ends of the range. y: a single cell, always zero.
        // z: a count above the maximum that saturates, with the largest inverse size.
        load_grid(32'h0, 32'h8000_0000, 32'h0,
                  32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  {11'd2047, 11'd1, 11'd4});
        positions_to_send.push_back(make_pos(32'h0000_0000, $urandom, 32'h0000_0000));
        positions_to_send.push_back(make_pos(32'h0000_8000, $urandom, 32'h0000_0001));
        positions_to_send.push_back(make_pos(32'h0000_8001, $urandom, 32'h0000_0002));
        positions_to_send.push_back(make_pos(32'h0001_8000, $urandom, 32'h0000_03FF));
        positions_to_send.push_back(make_pos(32'h0002_C000, $urandom, 32'h0000_0400));
        positions_to_send.push_back(make_pos(32'h0003_7FFF, $urandom, 32'h0000_0401));
        positions_to_send.push_back(make_pos(32'h0003_8000, $urandom, 32'h7FFF_FFFF));
        positions_to_send.push_back(make_pos(32'h7FFF_FFFF, $urandom, 32'h8000_0000));
        positions_to_send.push_back(make_pos(32'h8000_0000, $urandom, 32'hFFFF_FFFF));
        positions_to_send.push_back(make_pos(32'hFFFF_FFFF, $urandom, 32'h0000_0200));
        wait_drained();

        // A zero inverse size on one axis makes the whole grid invalid.
        load_grid(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000,
                  {11'd4, 11'd4, 11'd4});
        positions_to_send.push_back(make_pos(32'h0001_8000, 32'h0001_8000, 32'h0001_8000));
        positions_to_send.push_back(make_pos($urandom, $urandom, $urandom));
        wait_drained();

        // Extreme origins and sizes with every count saturated: the widest offset,
        // the smallest inverse size, and the edge of the last cell centre on z.
        load_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                  32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000, 33'h1_FFFF_FFFF);
        positions_to_send.push_back(make_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h03FF_8000));
        positions_to_send.push_back(make_pos(32'h8000_0000, 32'h8000_0000, 32'h03FF_7FFF));
        positions_to_send.push_back(make_pos(32'h8000_0001, 32'h7FFF_FFFE, 32'h0000_8001));
        positions_to_send.push_back(make_pos(32'h0000_0000, 32'h0000_0000, 32'hFFFF_8000));
        wait_drained();

        // A zero count on one axis also makes the grid invalid.
        load_grid(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                  {11'd5, 11'd5, 11'd0});
        positions_to_send.push_back(make_pos(32'h0002_0000, 32'h0002_0000, 32'h0002_0000));
        positions_to_send.push_back(make_pos($urandom, $urandom, $urandom));
        wait_drained();

        // Random part: a fresh grid per phase, each with an idle rate from the plan, and a
        // pause halfway through so the sender waits for all results at least once.
        for (int ph = 0; ph < 6; ph++)
        begin
            randomize_grid();
            idle_pct = idle_plan[ph];
            for (int n = 0; n < 205; n++)
            begin
                if (n == 100)
                    wait_drained();
                positions_to_send.push_back(make_pos(pick_coord(0), pick_coord(1),
                                                     pick_coord(2)));
            end
            wait_drained();
        end

        // Let any stray result beat show itself before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_cells.size() != 0)
            report_mismatch("results left outstanding", 64'(expected_cells.size()), 64'd0);

        if (mismatches == 0)
            $display("grid_cell_locate_trilinear_tb passed");
        else
            $display("grid_cell_locate_trilinear_tb failed");
        $finish;
    end

endmodule
